// ===== src/lav_pkg.sv =====
// Shared constants for the look-at view matrix block.
// No dependencies; used by lav_norm, look_at_view_matrix and lav_chk.
`timescale 1ns / 1ps

package lav_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_OUT        = 14;
  localparam int UNIT_W          = 16;
  localparam int NORM_BITS       = 30;               // largest magnitude scaled to [2^29, 2^30)
  localparam int NORM_TOP        = NORM_BITS - 1;
  localparam int SQ_W            = 2 * NORM_BITS + 2; // sum of three squares
  localparam int ROOT_W          = NORM_BITS + 1;
  localparam int SQRT_W          = 63;
  localparam int SQRT_STEPS      = 31;
  localparam int DIV_STEPS       = FRAC_OUT + 1;     // quotient never exceeds 2^14
  localparam int REM_W           = NORM_BITS + FRAC_OUT + 1;
  localparam int NORM_LAT        = 5 + SQRT_STEPS + 1 + DIV_STEPS + 1;
  localparam int TOP_LAT         = 1 + NORM_LAT + 4;
  localparam int UNIT_ONE        = 1 << FRAC_OUT;
  localparam int ROUND_HALF      = 1 << (FRAC_OUT - 1);

endpackage

// ===== src/lav_norm.sv =====
// Pipelined vector normalizer: scale, sum of squares, square root, division.
// Depends on lav_pkg. Takes one vector per cycle.
`timescale 1ns / 1ps

module lav_norm #(
  parameter int IN_W = lav_pkg::COORD_WIDTH_DEF + 1
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 valid_i,
  input  logic [2:0][IN_W-1:0]                 vec_i,
  output logic                                 valid_o,
  output logic [2:0][lav_pkg::UNIT_W-1:0]      unit_o
);

  localparam int PW  = $clog2(IN_W);
  localparam int XW  = IN_W + lav_pkg::NORM_BITS;
  localparam int NB  = lav_pkg::NORM_BITS;
  localparam int SS  = lav_pkg::SQRT_STEPS;
  localparam int DS  = lav_pkg::DIV_STEPS;
  localparam int RW  = lav_pkg::REM_W;
  localparam int QW  = lav_pkg::DIV_STEPS;
  localparam int SW  = lav_pkg::SQRT_W;

  // stage 1: magnitudes and signs
  logic                   v1_q;
  logic [2:0][IN_W-1:0]   mag1_q;
  logic [2:0]             neg1_q;
  logic [2:0][IN_W-1:0]   mag1_d;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag1_d[i] = vec_i[i][IN_W-1] ? (~vec_i[i] + IN_W'(1)) : vec_i[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else         v1_q <= valid_i;
  end

  always_ff @(posedge clk_i) begin
    mag1_q <= mag1_d;
    for (int i = 0; i < 3; i++) neg1_q[i] <= vec_i[i][IN_W-1];
  end

  // stage 2: leading one of the OR matches that of the largest magnitude
  logic                   v2_q, zero2_q;
  logic [PW-1:0]          pos2_q;
  logic [2:0][IN_W-1:0]   mag2_q;
  logic [2:0]             neg2_q;
  logic [IN_W-1:0]        orm;
  logic [PW-1:0]          pos_d;

  always_comb begin
    orm   = mag1_q[0] | mag1_q[1] | mag1_q[2];
    pos_d = '0;
    for (int b = 0; b < IN_W; b++) begin
      if (orm[b]) pos_d = PW'(b);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else         v2_q <= v1_q;
  end

  always_ff @(posedge clk_i) begin
    zero2_q <= (orm == '0);
    pos2_q  <= pos_d;
    mag2_q  <= mag1_q;
    neg2_q  <= neg1_q;
  end

  // stage 3: shift so the top bit lands on bit 29 (truncating right shift)
  logic                   v3_q, zero3_q;
  logic [2:0][NB-1:0]     m3_q, m3_d;
  logic [2:0]             neg3_q;

  always_comb begin
    logic [XW-1:0] wide;
    for (int i = 0; i < 3; i++) begin
      wide = XW'(mag2_q[i]);
      if (int'(pos2_q) > lav_pkg::NORM_TOP) begin
        wide = wide >> (int'(pos2_q) - lav_pkg::NORM_TOP);
      end else begin
        wide = wide << (lav_pkg::NORM_TOP - int'(pos2_q));
      end
      m3_d[i] = wide[NB-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else         v3_q <= v2_q;
  end

  always_ff @(posedge clk_i) begin
    zero3_q <= zero2_q;
    m3_q    <= m3_d;
    neg3_q  <= neg2_q;
  end

  // stage 4: squares
  logic                     v4_q, zero4_q;
  logic [2:0][2*NB-1:0]     sq4_q;
  logic [2:0][NB-1:0]       m4_q;
  logic [2:0]               neg4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v4_q <= 1'b0;
    else         v4_q <= v3_q;
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) sq4_q[i] <= m3_q[i] * m3_q[i];
    zero4_q <= zero3_q;
    m4_q    <= m3_q;
    neg4_q  <= neg3_q;
  end

  // stage 5 feeds the root pipeline: index 0 holds the sum of squares
  logic                   sv_q    [SS+1];
  logic                   szero_q [SS+1];
  logic [SW-1:0]          sx_q    [SS+1];
  logic [SW-1:0]          sr_q    [SS+1];
  logic [2:0][NB-1:0]     sm_q    [SS+1];
  logic [2:0]             sneg_q  [SS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sv_q[0] <= 1'b0;
    else         sv_q[0] <= v4_q;
  end

  always_ff @(posedge clk_i) begin
    sx_q[0]    <= SW'(sq4_q[0]) + SW'(sq4_q[1]) + SW'(sq4_q[2]);
    sr_q[0]    <= '0;
    szero_q[0] <= zero4_q;
    sm_q[0]    <= m4_q;
    sneg_q[0]  <= neg4_q;
  end

  // one root digit per stage
  for (genvar k = 0; k < SS; k++) begin : g_sqrt
    localparam logic [SW-1:0] RBIT = SW'(1) << (60 - 2 * k);
    logic [SW-1:0] trial;
    assign trial = sr_q[k] + RBIT;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) sv_q[k+1] <= 1'b0;
      else         sv_q[k+1] <= sv_q[k];
    end

    always_ff @(posedge clk_i) begin
      if (sx_q[k] >= trial) begin
        sx_q[k+1] <= sx_q[k] - trial;
        sr_q[k+1] <= (sr_q[k] >> 1) + RBIT;
      end else begin
        sx_q[k+1] <= sx_q[k];
        sr_q[k+1] <= sr_q[k] >> 1;
      end
      szero_q[k+1] <= szero_q[k];
      sm_q[k+1]    <= sm_q[k];
      sneg_q[k+1]  <= sneg_q[k];
    end
  end

  // divide setup: dividend is mag * 2^14 + n/2
  logic                          dv_q    [DS+1];
  logic                          dzero_q [DS+1];
  logic [lav_pkg::ROOT_W-1:0]    dn_q    [DS+1];
  logic [2:0][RW-1:0]            dr_q    [DS+1];
  logic [2:0][QW-1:0]            dq_q    [DS+1];
  logic [2:0]                    dneg_q  [DS+1];
  logic [lav_pkg::ROOT_W-1:0]    root;

  assign root = sr_q[SS][lav_pkg::ROOT_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) dv_q[0] <= 1'b0;
    else         dv_q[0] <= sv_q[SS];
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      dr_q[0][i] <= (RW'(sm_q[SS][i]) << lav_pkg::FRAC_OUT) + RW'(root >> 1);
    end
    dq_q[0]    <= '0;
    dn_q[0]    <= root;
    dzero_q[0] <= szero_q[SS];
    dneg_q[0]  <= sneg_q[SS];
  end

  // restoring division, one quotient bit per stage, MSB first
  for (genvar j = 0; j < DS; j++) begin : g_div
    localparam int QB = DS - 1 - j;
    logic [RW-1:0] dvs;
    assign dvs = RW'(dn_q[j]) << QB;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) dv_q[j+1] <= 1'b0;
      else         dv_q[j+1] <= dv_q[j];
    end

    always_ff @(posedge clk_i) begin
      for (int i = 0; i < 3; i++) begin
        if (dr_q[j][i] >= dvs) begin
          dr_q[j+1][i]     <= dr_q[j][i] - dvs;
          dq_q[j+1][i]     <= dq_q[j][i] | (QW'(1) << QB);
        end else begin
          dr_q[j+1][i]     <= dr_q[j][i];
          dq_q[j+1][i]     <= dq_q[j][i];
        end
      end
      dn_q[j+1]    <= dn_q[j];
      dzero_q[j+1] <= dzero_q[j];
      dneg_q[j+1]  <= dneg_q[j];
    end
  end

  // sign back on; zero-length vector gives a zero row
  logic                              vo_q;
  logic [2:0][lav_pkg::UNIT_W-1:0]   unit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vo_q <= 1'b0;
    else         vo_q <= dv_q[DS];
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      if (dzero_q[DS]) begin
        unit_q[i] <= '0;
      end else if (dneg_q[DS][i]) begin
        unit_q[i] <= -lav_pkg::UNIT_W'(dq_q[DS][i]);
      end else begin
        unit_q[i] <= lav_pkg::UNIT_W'(dq_q[DS][i]);
      end
    end
  end

  assign valid_o = vo_q;
  assign unit_o  = unit_q;

endmodule

// ===== src/look_at_view_matrix.sv =====
// Look-at view matrix: basis rows and translations from eye, target and up.
// Depends on lav_pkg and lav_norm.
`timescale 1ns / 1ps

// Usage:
//   Input channel: drive eye, target and up (signed Q16.16, COORD_WIDTH bits)
//   with start high; a beat is taken at every rising edge where start is high
//   and busy is low. busy stays low, so a new set-up can go in every cycle.
//   Result channel: done_o pulses for one cycle with side/vert/back rows
//   (Q2.14) and the three translations (Q16.16, saturated) valid in that
//   cycle. The receiver cannot stall; results are shown once and dropped.
//   Throughput: one beat per cycle. Most pipeline stages lie in the square
//   root (31 stages, one root bit each) and the division (15 stages, one
//   quotient bit each) inside each of the two normalizers.
//   Reset (rst_ni low, asynchronous) clears every valid bit in the pipe, so
//   beats in flight are discarded; no result is produced for them.

module look_at_view_matrix #(
  parameter int COORD_WIDTH = lav_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] eye_x_i,
  input  logic signed [COORD_WIDTH-1:0] eye_y_i,
  input  logic signed [COORD_WIDTH-1:0] eye_z_i,
  input  logic signed [COORD_WIDTH-1:0] target_x_i,
  input  logic signed [COORD_WIDTH-1:0] target_y_i,
  input  logic signed [COORD_WIDTH-1:0] target_z_i,
  input  logic signed [COORD_WIDTH-1:0] upward_x_i,
  input  logic signed [COORD_WIDTH-1:0] upward_y_i,
  input  logic signed [COORD_WIDTH-1:0] upward_z_i,
  output logic                          done_o,
  output logic signed [15:0]            side_x_o,
  output logic signed [15:0]            side_y_o,
  output logic signed [15:0]            side_z_o,
  output logic signed [15:0]            vert_x_o,
  output logic signed [15:0]            vert_y_o,
  output logic signed [15:0]            vert_z_o,
  output logic signed [15:0]            back_x_o,
  output logic signed [15:0]            back_y_o,
  output logic signed [15:0]            back_z_o,
  output logic signed [31:0]            shift_side_o,
  output logic signed [31:0]            shift_vert_o,
  output logic signed [31:0]            shift_back_o
);

  localparam int IW  = COORD_WIDTH + 1;
  localparam int UW  = lav_pkg::UNIT_W;
  localparam int NL  = lav_pkg::NORM_LAT;
  localparam int PRW = UW + COORD_WIDTH;
  localparam int SMW = PRW + 2;
  localparam int NGW = SMW + 1;
  localparam int XPW = 2 * UW + 1;
  localparam int XRW = XPW - lav_pkg::FRAC_OUT;
  localparam logic signed [NGW-1:0] SAT_HI = NGW'(64'sd2147483647);
  localparam logic signed [NGW-1:0] SAT_LO = NGW'(-64'sd2147483648);
  localparam logic signed [XRW-1:0] A_HI   = XRW'(32'sd32767);
  localparam logic signed [XRW-1:0] A_LO   = XRW'(-32'sd32768);

  logic accept;
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // input register: eye minus target widened by one bit
  logic                               v0_q;
  logic [2:0][IW-1:0]                 dif_q, upv_q;
  logic [2:0][COORD_WIDTH-1:0]        eye0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v0_q <= 1'b0;
    else         v0_q <= accept;
  end

  always_ff @(posedge clk_i) begin
    dif_q[0] <= IW'(eye_x_i) - IW'(target_x_i);
    dif_q[1] <= IW'(eye_y_i) - IW'(target_y_i);
    dif_q[2] <= IW'(eye_z_i) - IW'(target_z_i);
    upv_q[0] <= IW'(upward_x_i);
    upv_q[1] <= IW'(upward_y_i);
    upv_q[2] <= IW'(upward_z_i);
    eye0_q   <= {eye_z_i, eye_y_i, eye_x_i};
  end

  logic                  vc, vb;
  logic [2:0][UW-1:0]    cu, bu;

  lav_norm #(.IN_W(IW)) u_norm_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v0_q),
    .vec_i   (dif_q),
    .valid_o (vc),
    .unit_o  (cu)
  );

  lav_norm #(.IN_W(IW)) u_norm_vert (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v0_q),
    .vec_i   (upv_q),
    .valid_o (vb),
    .unit_o  (bu)
  );

  // eye rides alongside the normalizers
  logic [2:0][COORD_WIDTH-1:0] eye_dly_q [NL];

  always_ff @(posedge clk_i) begin
    eye_dly_q[0] <= eye0_q;
    for (int s = 1; s < NL; s++) eye_dly_q[s] <= eye_dly_q[s-1];
  end

  // T1: cross product partial products
  logic                            v1_q;
  logic signed [2*UW-1:0]          pa_q [3];
  logic signed [2*UW-1:0]          pb_q [3];
  logic signed [UW-1:0]            b1_q [3];
  logic signed [UW-1:0]            c1_q [3];
  logic [2:0][COORD_WIDTH-1:0]     eye1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else         v1_q <= vc & vb;
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      pa_q[i] <= $signed(bu[(i+1)%3]) * $signed(cu[(i+2)%3]);
      pb_q[i] <= $signed(bu[(i+2)%3]) * $signed(cu[(i+1)%3]);
      b1_q[i] <= $signed(bu[i]);
      c1_q[i] <= $signed(cu[i]);
    end
    eye1_q <= eye_dly_q[NL-1];
  end

  // T2: side row, rounded half up and saturated
  logic                            v2_q;
  logic signed [UW-1:0]            a2_q [3];
  logic signed [UW-1:0]            b2_q [3];
  logic signed [UW-1:0]            c2_q [3];
  logic [2:0][COORD_WIDTH-1:0]     eye2_q;
  logic signed [UW-1:0]            a2_d [3];

  always_comb begin
    logic signed [XPW-1:0] x;
    logic signed [XRW-1:0] r;
    for (int i = 0; i < 3; i++) begin
      x = XPW'(pa_q[i]) - XPW'(pb_q[i]) + XPW'(lav_pkg::ROUND_HALF);
      r = XRW'(x >>> lav_pkg::FRAC_OUT);
      if (r > A_HI)      a2_d[i] = A_HI[UW-1:0];
      else if (r < A_LO) a2_d[i] = A_LO[UW-1:0];
      else               a2_d[i] = r[UW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else         v2_q <= v1_q;
  end

  always_ff @(posedge clk_i) begin
    a2_q   <= a2_d;
    b2_q   <= b1_q;
    c2_q   <= c1_q;
    eye2_q <= eye1_q;
  end

  // T3: row times eye products (row 0 side, 1 vert, 2 back)
  logic                     v3_q;
  logic signed [PRW-1:0]    dp_q [3][3];
  logic signed [UW-1:0]     a3_q [3];
  logic signed [UW-1:0]     b3_q [3];
  logic signed [UW-1:0]     c3_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else         v3_q <= v2_q;
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      dp_q[0][i] <= PRW'(a2_q[i]) * PRW'($signed(eye2_q[i]));
      dp_q[1][i] <= PRW'(b2_q[i]) * PRW'($signed(eye2_q[i]));
      dp_q[2][i] <= PRW'(c2_q[i]) * PRW'($signed(eye2_q[i]));
    end
    a3_q <= a2_q;
    b3_q <= b2_q;
    c3_q <= c2_q;
  end

  // T4: sum, round half up, negate, saturate; these are the output registers
  logic                   v4_q;
  logic signed [31:0]     sh_q [3];
  logic signed [31:0]     sh_d [3];
  logic signed [UW-1:0]   a4_q [3];
  logic signed [UW-1:0]   b4_q [3];
  logic signed [UW-1:0]   c4_q [3];

  always_comb begin
    logic signed [SMW-1:0] s;
    logic signed [NGW-1:0] t;
    for (int r = 0; r < 3; r++) begin
      s = SMW'(dp_q[r][0]) + SMW'(dp_q[r][1]) + SMW'(dp_q[r][2])
          + SMW'(lav_pkg::ROUND_HALF);
      t = -(NGW'(s >>> lav_pkg::FRAC_OUT));
      if (t > SAT_HI)      sh_d[r] = SAT_HI[31:0];
      else if (t < SAT_LO) sh_d[r] = SAT_LO[31:0];
      else                 sh_d[r] = t[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v4_q <= 1'b0;
    else         v4_q <= v3_q;
  end

  always_ff @(posedge clk_i) begin
    sh_q <= sh_d;
    a4_q <= a3_q;
    b4_q <= b3_q;
    c4_q <= c3_q;
  end

  assign done_o       = v4_q;
  assign side_x_o     = a4_q[0];
  assign side_y_o     = a4_q[1];
  assign side_z_o     = a4_q[2];
  assign vert_x_o     = b4_q[0];
  assign vert_y_o     = b4_q[1];
  assign vert_z_o     = b4_q[2];
  assign back_x_o     = c4_q[0];
  assign back_y_o     = c4_q[1];
  assign back_z_o     = c4_q[2];
  assign shift_side_o = sh_q[0];
  assign shift_vert_o = sh_q[1];
  assign shift_back_o = sh_q[2];

endmodule

// ===== src/lav_chk.sv =====
// Port-level checks for look_at_view_matrix, attached by bind.
// Depends on lav_pkg and on the ports of look_at_view_matrix.
`timescale 1ns / 1ps

module lav_chk #(
  parameter int COORD_WIDTH = lav_pkg::COORD_WIDTH_DEF
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start,
  input logic                          busy,
  input logic signed [COORD_WIDTH-1:0] eye_x_i,
  input logic signed [COORD_WIDTH-1:0] eye_y_i,
  input logic signed [COORD_WIDTH-1:0] eye_z_i,
  input logic signed [COORD_WIDTH-1:0] target_x_i,
  input logic signed [COORD_WIDTH-1:0] target_y_i,
  input logic signed [COORD_WIDTH-1:0] target_z_i,
  input logic signed [COORD_WIDTH-1:0] upward_x_i,
  input logic signed [COORD_WIDTH-1:0] upward_y_i,
  input logic signed [COORD_WIDTH-1:0] upward_z_i,
  input logic                          done_o,
  input logic signed [15:0]            side_x_o,
  input logic signed [15:0]            side_y_o,
  input logic signed [15:0]            side_z_o,
  input logic signed [15:0]            vert_x_o,
  input logic signed [15:0]            vert_y_o,
  input logic signed [15:0]            vert_z_o,
  input logic signed [15:0]            back_x_o,
  input logic signed [15:0]            back_y_o,
  input logic signed [15:0]            back_z_o,
  input logic signed [31:0]            shift_side_o,
  input logic signed [31:0]            shift_vert_o,
  input logic signed [31:0]            shift_back_o
);

  localparam int LAT = lav_pkg::TOP_LAT;
  localparam int CW  = $clog2(LAT + 1);
  localparam logic signed [15:0] ONE_P = 16'(lav_pkg::UNIT_ONE);
  localparam logic signed [15:0] ONE_N = -16'(lav_pkg::UNIT_ONE);

  logic          acc;
  logic [CW-1:0] age_q;

  assign acc = start & ~busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)              age_q <= '0;
    else if (age_q != CW'(LAT)) age_q <= age_q + CW'(1);
  end

  // every accepted beat gives exactly one strobe, a fixed latency later
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    age_q == CW'(LAT) |-> done_o == $past(acc, LAT))
    else $error("result strobe does not match accepted beat");

  a_zero_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && upward_x_i == '0 && upward_y_i == '0 && upward_z_i == '0 |-> ##LAT
    (done_o && vert_x_o == '0 && vert_y_o == '0 && vert_z_o == '0 &&
     side_x_o == '0 && side_y_o == '0 && side_z_o == '0 && shift_vert_o == '0 &&
     shift_side_o == '0))
    else $error("zero up vector must give zero vertical and side rows");

  a_zero_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && eye_x_i == target_x_i && eye_y_i == target_y_i && eye_z_i == target_z_i
    |-> ##LAT
    (done_o && back_x_o == '0 && back_y_o == '0 && back_z_o == '0 &&
     side_x_o == '0 && side_y_o == '0 && side_z_o == '0 && shift_back_o == '0))
    else $error("eye on target must give zero back and side rows");

  a_unit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> vert_x_o <= ONE_P && vert_x_o >= ONE_N &&
               vert_y_o <= ONE_P && vert_y_o >= ONE_N &&
               vert_z_o <= ONE_P && vert_z_o >= ONE_N &&
               back_x_o <= ONE_P && back_x_o >= ONE_N &&
               back_y_o <= ONE_P && back_y_o >= ONE_N &&
               back_z_o <= ONE_P && back_z_o >= ONE_N)
    else $error("normalized component beyond one");

endmodule

bind look_at_view_matrix lav_chk #(.COORD_WIDTH(COORD_WIDTH)) u_lav_chk (.*);
